### sv/change_record_byte_parser_unit_assert.svh
// Assertion macros shared by the change record byte parser RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CHANGE_RECORD_BYTE_PARSER_UNIT_ASSERT_SVH
`define CHANGE_RECORD_BYTE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define CRBP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CRBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/crbp_pkg.sv
// Shared types and constants for the change record byte parser.
// No dependencies; used by crbp_parser, crbp_outq and the top level.
package crbp_pkg;

    // Default width of the value length field
    localparam int VALUE_LEN_BITS_DEF = 32;
    // Accumulator must hold an unsigned 32-bit relation id plus headroom
    localparam int ACC_MIN_W = 33;
    // Result queue depth (power of two)
    localparam int OUTQ_DEPTH = 4;

    // Characters of the record syntax
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Integer limits
    localparam logic [31:0] REL_LIM     = 32'hFFFF_FFFF;
    localparam logic [31:0] INT_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_NEG_LIM = 32'h8000_0000;

    typedef enum logic [3:0] {
        PH_ACTION = 4'd0,
        PH_TAB    = 4'd1,
        PH_RELID  = 4'd2,
        PH_NCOLS  = 4'd3,
        PH_ATTR   = 4'd4,
        PH_NULL   = 4'd5,
        PH_LEN    = 4'd6,
        PH_VALUE  = 4'd7,
        PH_SEP    = 4'd8,
        PH_SKIP   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_COLUMN = 2'd1,
        EV_VALUE  = 2'd2,
        EV_END    = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MALFORMED  = 3'd1,
        ST_BAD_INT    = 3'd2,
        ST_BAD_NULL   = 3'd3,
        ST_NO_COLON   = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_BAD_SEP    = 3'd6,
        ST_BAD_ATTR   = 3'd7
    } status_t;

    // Token flags; aux is the minus sign or, from the null token on, the null marker
    typedef struct packed {
        logic aux;
        logic ovf;
        logic bad;
        logic digit;
    } flags_t;

    // One result item
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  action;
        logic [31:0] relation;
        logic [30:0] count;
        logic [30:0] attr;
        logic        is_null;
        logic [31:0] length;
        logic [7:0]  vbyte;
        status_t     status;
        logic        last;
    } row_t;

    // Results of one accepted byte, in order
    typedef struct packed {
        logic [1:0] n;
        row_t       row0;
        row_t       row1;
    } push_t;

endpackage

### sv/crbp_parser.sv
// Record parse state and per-byte step logic of the change record parser.
// Depends on crbp_pkg and change_record_byte_parser_unit_assert.svh.
`include "change_record_byte_parser_unit_assert.svh"

module crbp_parser import crbp_pkg::*; #(
    parameter int VALUE_LEN_BITS = VALUE_LEN_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_eor,
    output push_t      push
);

    localparam int LEN_W = VALUE_LEN_BITS;
    localparam int ACC_W = (VALUE_LEN_BITS > ACC_MIN_W) ? VALUE_LEN_BITS : ACC_MIN_W;
    localparam int PW    = ACC_W + 4;

    phase_t             phase_reg, phase_next;
    logic [7:0]         action_reg, action_next;
    logic [31:0]        relation_reg, relation_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    flags_t             flags_reg, flags_next;
    logic [30:0]        cols_reg, cols_next;
    logic [30:0]        attr_reg, attr_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    status_t            perr_reg, perr_next;

    // Number feed unit
    logic               allow_minus;
    logic               is_digit;
    logic [PW-1:0]      lim;
    logic [PW-1:0]      acc10;
    logic [ACC_W-1:0]   feed_acc;
    flags_t             feed_flags;
    logic               tok_valid;

    // Result assembly
    logic               main_vld, hdr_vld;
    row_t               main_row, hdr_row, end_row;
    push_t              step;

    // Integer limit for the current token and one decimal step
    always_comb begin
        allow_minus = (phase_reg == PH_NCOLS) || (phase_reg == PH_ATTR);
        is_digit    = (in_byte >= CH_0) && (in_byte <= CH_9);
        if (phase_reg == PH_LEN) begin
            lim = PW'({LEN_W{1'b1}});
        end else if (phase_reg == PH_RELID) begin
            lim = PW'(REL_LIM);
        end else if (flags_reg.aux) begin
            lim = PW'(INT_NEG_LIM);
        end else begin
            lim = PW'(INT_POS_LIM);
        end
        acc10 = (PW'(acc_reg) << 3) + (PW'(acc_reg) << 1) + PW'(in_byte[3:0]);
    end

    // Feed one character into the current numeric token
    always_comb begin
        feed_acc   = acc_reg;
        feed_flags = flags_reg;
        if (!flags_reg.bad) begin
            if ((in_byte == CH_MINUS) && allow_minus && !flags_reg.digit && !flags_reg.aux) begin
                feed_flags.aux = 1'b1;
            end else if (!is_digit) begin
                feed_flags.bad = 1'b1;
            end else begin
                feed_flags.digit = 1'b1;
                if (!flags_reg.ovf) begin
                    if (acc10 > lim) begin
                        feed_flags.ovf = 1'b1;
                    end else begin
                        feed_acc = acc10[ACC_W-1:0];
                    end
                end
            end
        end
    end

    assign tok_valid = flags_reg.digit && !flags_reg.bad && !flags_reg.ovf;

    // Step: phase transition, events, then end-of-record handling
    always_comb begin
        phase_next    = phase_reg;
        action_next   = action_reg;
        relation_next = relation_reg;
        acc_next      = acc_reg;
        flags_next    = flags_reg;
        cols_next     = cols_reg;
        attr_next     = attr_reg;
        remain_next   = remain_reg;
        perr_next     = perr_reg;
        main_vld      = 1'b0;
        hdr_vld       = 1'b0;
        main_row      = '0;
        hdr_row       = '0;
        end_row       = '0;
        step          = '0;

        unique case (phase_reg)
            PH_ACTION: begin
                action_next = in_byte;
                phase_next  = PH_TAB;
            end
            PH_TAB: begin
                if (in_byte == CH_TAB) begin
                    phase_next = PH_RELID;
                    acc_next   = '0;
                    flags_next = '0;
                end else begin
                    perr_next  = ST_MALFORMED;
                    phase_next = PH_SKIP;
                end
            end
            PH_RELID: begin
                if (in_byte != CH_TAB) begin
                    acc_next   = feed_acc;
                    flags_next = feed_flags;
                end else if (!tok_valid) begin
                    perr_next  = ST_BAD_INT;
                    phase_next = PH_SKIP;
                end else begin
                    relation_next = acc_reg[31:0];
                    if (action_reg != CH_I) begin
                        main_vld          = 1'b1;
                        main_row.kind     = EV_HEADER;
                        main_row.action   = action_reg;
                        main_row.relation = acc_reg[31:0];
                        perr_next         = ST_OK;
                        phase_next        = PH_SKIP;
                    end else begin
                        phase_next = PH_NCOLS;
                        acc_next   = '0;
                        flags_next = '0;
                    end
                end
            end
            PH_NCOLS: begin
                if (in_byte != CH_TAB) begin
                    acc_next   = feed_acc;
                    flags_next = feed_flags;
                end else if (!tok_valid || (flags_reg.aux && (acc_reg != '0))) begin
                    perr_next  = ST_BAD_INT;
                    phase_next = PH_SKIP;
                end else begin
                    main_vld          = 1'b1;
                    main_row.kind     = EV_HEADER;
                    main_row.action   = action_reg;
                    main_row.relation = relation_reg;
                    main_row.count    = acc_reg[30:0];
                    if (acc_reg == '0) begin
                        perr_next  = ST_OK;
                        phase_next = PH_SKIP;
                    end else begin
                        cols_next  = acc_reg[30:0];
                        phase_next = PH_ATTR;
                        acc_next   = '0;
                        flags_next = '0;
                    end
                end
            end
            PH_ATTR: begin
                if (in_byte != CH_TAB) begin
                    acc_next   = feed_acc;
                    flags_next = feed_flags;
                end else if (!tok_valid) begin
                    perr_next  = ST_BAD_INT;
                    phase_next = PH_SKIP;
                end else begin
                    // non-positive attribute: fail after this column
                    if (flags_reg.aux || (acc_reg == '0)) begin
                        perr_next = ST_BAD_ATTR;
                        attr_next = '0;
                    end else begin
                        perr_next = ST_OK;
                        attr_next = acc_reg[30:0];
                    end
                    phase_next = PH_NULL;
                    acc_next   = '0;
                    flags_next = '0;
                end
            end
            PH_NULL: begin
                if (in_byte == CH_TAB) begin
                    if (!flags_reg.digit || flags_reg.bad) begin
                        perr_next  = ST_BAD_NULL;
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_LEN;
                        acc_next   = '0;
                        flags_next = '{aux: flags_reg.aux, default: 1'b0};
                    end
                end else if (flags_reg.digit || ((in_byte != CH_N) && (in_byte != CH_V))) begin
                    flags_next.bad = 1'b1;
                end else begin
                    flags_next.digit = 1'b1;
                    if (in_byte == CH_N) begin
                        flags_next.aux = 1'b1;
                    end
                end
            end
            PH_LEN: begin
                if (in_byte != CH_COLON) begin
                    acc_next   = feed_acc;
                    flags_next = feed_flags;
                end else if (!tok_valid) begin
                    perr_next  = ST_BAD_INT;
                    phase_next = PH_SKIP;
                end else begin
                    remain_next = acc_reg[LEN_W-1:0];
                    if (perr_reg != ST_BAD_ATTR) begin
                        main_vld         = 1'b1;
                        main_row.kind    = EV_COLUMN;
                        main_row.attr    = attr_reg;
                        main_row.is_null = flags_reg.aux;
                        main_row.length  = acc_reg[31:0];
                    end
                    if (acc_reg == '0) begin
                        phase_next = (cols_reg <= 31'd1) ? PH_SKIP : PH_SEP;
                    end else begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                if (!flags_reg.aux && (perr_reg != ST_BAD_ATTR)) begin
                    main_vld       = 1'b1;
                    main_row.kind  = EV_VALUE;
                    main_row.attr  = attr_reg;
                    main_row.vbyte = in_byte;
                end
                remain_next = remain_reg - LEN_W'(1);
                if (remain_reg == LEN_W'(1)) begin
                    phase_next = (cols_reg <= 31'd1) ? PH_SKIP : PH_SEP;
                end
            end
            PH_SEP: begin
                if (in_byte != CH_TAB) begin
                    perr_next  = ST_BAD_SEP;
                    phase_next = PH_SKIP;
                end else if (perr_reg == ST_BAD_ATTR) begin
                    phase_next = PH_SKIP;
                end else begin
                    cols_next  = cols_reg - 31'd1;
                    phase_next = PH_ATTR;
                    acc_next   = '0;
                    flags_next = '0;
                end
            end
            default: begin
            end
        endcase

        // Record end: status from the phase reached, then full clear
        if (in_eor) begin
            end_row.kind = EV_END;
            unique case (phase_next)
                PH_RELID: begin
                    if (!flags_next.digit && !flags_next.bad) begin
                        end_row.status = ST_MALFORMED;
                    end else if (!flags_next.digit || flags_next.bad || flags_next.ovf) begin
                        end_row.status = ST_BAD_INT;
                    end else if (action_next != CH_I) begin
                        hdr_vld          = 1'b1;
                        hdr_row.kind     = EV_HEADER;
                        hdr_row.action   = action_next;
                        hdr_row.relation = acc_next[31:0];
                        end_row.status   = ST_OK;
                    end else begin
                        end_row.status = ST_MALFORMED;
                    end
                end
                PH_LEN:   end_row.status = ST_NO_COLON;
                PH_VALUE: end_row.status = ST_TRUNCATED;
                PH_SEP:   end_row.status = ST_BAD_SEP;
                PH_SKIP:  end_row.status = perr_next;
                default:  end_row.status = ST_MALFORMED;
            endcase
            end_row.last  = 1'b1;
            phase_next    = PH_ACTION;
            action_next   = '0;
            relation_next = '0;
            acc_next      = '0;
            flags_next    = '0;
            cols_next     = '0;
            attr_next     = '0;
            remain_next   = '0;
            perr_next     = ST_OK;
        end

        // Order the step's results
        if (main_vld) begin
            step.row0 = main_row;
            if (in_eor) begin
                step.row1 = end_row;
                step.n    = 2'd2;
            end else begin
                step.row0.last = 1'b1;
                step.n         = 2'd1;
            end
        end else if (hdr_vld) begin
            step.row0 = hdr_row;
            step.row1 = end_row;
            step.n    = 2'd2;
        end else if (in_eor) begin
            step.row0 = end_row;
            step.n    = 2'd1;
        end
    end

    assign push = in_accept ? step : '0;

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ACTION;
            action_reg   <= '0;
            relation_reg <= '0;
            acc_reg      <= '0;
            flags_reg    <= '0;
            cols_reg     <= '0;
            attr_reg     <= '0;
            remain_reg   <= '0;
            perr_reg     <= ST_OK;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            action_reg   <= action_next;
            relation_reg <= relation_next;
            acc_reg      <= acc_next;
            flags_reg    <= flags_next;
            cols_reg     <= cols_next;
            attr_reg     <= attr_next;
            remain_reg   <= remain_next;
            perr_reg     <= perr_next;
        end
    end

    `CRBP_ASSERT_NEXT(a_eor_restarts, aclk, aresetn, in_accept && in_eor, (phase_reg == PH_ACTION) && (perr_reg == ST_OK), "record end did not restart parsing")
    `CRBP_ASSERT_IMPL(a_eor_ends_step, aclk, aresetn, in_accept && in_eor, ((push.n == 2'd1) && (push.row0.kind == EV_END)) || ((push.n == 2'd2) && (push.row1.kind == EV_END)), "record end event missing or misplaced")
    `CRBP_ASSERT_IMPL(a_value_pending, aclk, aresetn, phase_reg == PH_VALUE, remain_reg != '0, "value phase with no bytes remaining")
    `CRBP_ASSERT_IMPL(a_sep_has_cols, aclk, aresetn, phase_reg == PH_SEP, cols_reg > 31'd1, "separator expected after last column")

endmodule

### sv/crbp_outq.sv
// Result queue of the change record parser: takes up to two results per cycle.
// Depends on crbp_pkg.
module crbp_outq import crbp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  space_ok,
    output logic  m_valid,
    input  logic  m_ready,
    output row_t  m_row
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    row_t             slot_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // Flags and read side
    assign space_ok    = count_reg <= CNT_W'(OUTQ_DEPTH - 2);
    assign m_valid     = count_reg != '0;
    assign m_row       = slot_reg[rd_ptr_reg];
    assign pop         = m_valid && m_ready;
    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.row0;
        end
        if (push.n == 2'd2) begin
            slot_reg[wr_ptr_inc] <= push.row1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/change_record_byte_parser_unit.sv
// Top level of the change record byte parser.
// Depends on crbp_pkg, crbp_parser and crbp_outq.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    data_byte, end_of_record
// m_       out  m_valid/m_ready    event, record and column fields, last_of_step
//
// One byte is parsed per cycle while s_ready is high; its results enter a 4-entry
// queue on the same edge and are offered on m_ from the next cycle, one per transfer.
// A byte yields at most two results (an event plus the record end), so the
// queue's drain rate sets throughput: one byte per cycle while each yields one.
// s_ready drops when fewer than two queue entries are free.
// Reset (aresetn, synchronous) returns to the start of a record and empties the queue.
module change_record_byte_parser_unit import crbp_pkg::*; #(
    parameter int VALUE_LEN_BITS = VALUE_LEN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_record,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_action_code,
    output logic [31:0] m_relation_id,
    output logic [30:0] m_column_count,
    output logic [30:0] m_attribute_number,
    output logic        m_value_is_null,
    output logic [31:0] m_value_length,
    output logic [7:0]  m_value_byte,
    output logic [2:0]  m_record_status,
    output logic        m_last_of_step
);

    logic  in_accept;
    logic  space_ok;
    push_t push;
    row_t  m_row;

    // Input transfer
    assign s_ready   = space_ok;
    assign in_accept = s_valid && space_ok;

    crbp_parser #(
        .VALUE_LEN_BITS (VALUE_LEN_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_data_byte),
        .in_eor    (s_end_of_record),
        .push      (push)
    );

    crbp_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_row    (m_row)
    );

    // Result fields
    assign m_event_kind       = m_row.kind;
    assign m_action_code      = m_row.action;
    assign m_relation_id      = m_row.relation;
    assign m_column_count     = m_row.count;
    assign m_attribute_number = m_row.attr;
    assign m_value_is_null    = m_row.is_null;
    assign m_value_length     = m_row.length;
    assign m_value_byte       = m_row.vbyte;
    assign m_record_status    = m_row.status;
    assign m_last_of_step     = m_row.last;

endmodule

### bench/tb_change_record_byte_parser_unit.sv
// Self-checking testbench for change_record_byte_parser_unit.
// Drives whole change records byte by byte and checks every event against a
// built-in parser model; depends on crbp_pkg and the RTL only.
module tb_change_record_byte_parser_unit import crbp_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] LEN_LIMIT = (64'd1 << VALUE_LEN_BITS_DEF) - 64'd1;
    localparam logic [63:0] REL_LIMIT = 64'hFFFF_FFFF;
    localparam logic [63:0] INT_LIMIT = 64'h7FFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_record = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_action_code;
    logic [31:0] m_relation_id;
    logic [30:0] m_column_count;
    logic [30:0] m_attribute_number;
    logic        m_value_is_null;
    logic [31:0] m_value_length;
    logic [7:0]  m_value_byte;
    logic [2:0]  m_record_status;
    logic        m_last_of_step;

    change_record_byte_parser_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_end_of_record    (s_end_of_record),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_action_code      (m_action_code),
        .m_relation_id      (m_relation_id),
        .m_column_count     (m_column_count),
        .m_attribute_number (m_attribute_number),
        .m_value_is_null    (m_value_is_null),
        .m_value_length     (m_value_length),
        .m_value_byte       (m_value_byte),
        .m_record_status    (m_record_status),
        .m_last_of_step     (m_last_of_step)
    );

    // Clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Parser model state
    phase_t      ph;
    logic [7:0]  act_r;
    logic [31:0] rel_r;
    logic [63:0] acc_r;
    flags_t      flg;
    logic [31:0] cols_r;
    logic [31:0] attr_r;
    logic [63:0] remain_r;
    status_t     err_r;

    row_t        step_rows[$];
    row_t        pending_events[$];
    logic [7:0]  rec_q[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          bytes_sent = 0;
    int          err_count = 0;
    int unsigned cycle_cnt = 0;
    row_t        got_row;
    row_t        want_row;

    // ---------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------
    function automatic void clear_parser();
        ph       = PH_ACTION;
        act_r    = '0;
        rel_r    = '0;
        acc_r    = '0;
        flg      = '0;
        cols_r   = '0;
        attr_r   = '0;
        remain_r = '0;
        err_r    = ST_OK;
    endfunction

    function automatic void start_token(bit keep_aux);
        logic a;
        a     = keep_aux & flg.aux;
        acc_r = '0;
        flg   = '0;
        flg.aux = a;
    endfunction

    function automatic void go_skip(status_t e);
        err_r = e;
        ph    = PH_SKIP;
    endfunction

    function automatic bit token_ok();
        return flg.digit && !flg.bad && !flg.ovf;
    endfunction

    // Decimal digit accumulation with optional leading minus and range check
    function automatic void feed_digit(logic [7:0] b, bit signed_ok, logic [63:0] lim);
        logic [63:0] d;
        if (flg.bad)
            return;
        if (b == CH_MINUS && signed_ok && !flg.digit && !flg.aux) begin
            flg.aux = 1'b1;
            return;
        end
        if (b < CH_0 || b > CH_9) begin
            flg.bad = 1'b1;
            return;
        end
        flg.digit = 1'b1;
        if (flg.ovf)
            return;
        d = {56'd0, b - CH_0};
        if (signed_ok && flg.aux)
            lim = lim + 64'd1;
        if (acc_r > (lim - d) / 64'd10)
            flg.ovf = 1'b1;
        else
            acc_r = acc_r * 64'd10 + d;
    endfunction

    function automatic void finish_value();
        if (cols_r <= 32'd1)
            go_skip(err_r);
        else
            ph = PH_SEP;
    endfunction

    function automatic void add_header(logic [31:0] cnt);
        row_t r;
        r = '0;
        r.kind     = EV_HEADER;
        r.action   = act_r;
        r.relation = rel_r;
        r.count    = cnt[30:0];
        step_rows.insert(step_rows.size(), r);
    endfunction

    function automatic void add_column();
        row_t r;
        r = '0;
        r.kind    = EV_COLUMN;
        r.attr    = attr_r[30:0];
        r.is_null = flg.aux;
        r.length  = remain_r[31:0];
        step_rows.insert(step_rows.size(), r);
    endfunction

    function automatic void add_value(logic [7:0] b);
        row_t r;
        r = '0;
        r.kind  = EV_VALUE;
        r.attr  = attr_r[30:0];
        r.vbyte = b;
        step_rows.insert(step_rows.size(), r);
    endfunction

    function automatic void add_end(status_t st);
        row_t r;
        r = '0;
        r.kind   = EV_END;
        r.status = st;
        step_rows.insert(step_rows.size(), r);
    endfunction

    // Expected events of one accepted byte, appended to pending_events
    function automatic void predict_parser_events(logic [7:0] b, logic eor);
        status_t st;
        row_t    r;
        step_rows.delete();
        case (ph)
            PH_ACTION: begin
                act_r = b;
                ph    = PH_TAB;
            end
            PH_TAB: begin
                if (b == CH_TAB) begin
                    ph = PH_RELID;
                    start_token(1'b0);
                end else begin
                    go_skip(ST_MALFORMED);
                end
            end
            PH_RELID: begin
                if (b != CH_TAB) begin
                    feed_digit(b, 1'b0, REL_LIMIT);
                end else if (!token_ok()) begin
                    go_skip(ST_BAD_INT);
                end else begin
                    rel_r = acc_r[31:0];
                    if (act_r != CH_I) begin
                        add_header('0);
                        go_skip(ST_OK);
                    end else begin
                        ph = PH_NCOLS;
                        start_token(1'b0);
                    end
                end
            end
            PH_NCOLS: begin
                if (b != CH_TAB) begin
                    feed_digit(b, 1'b1, INT_LIMIT);
                end else if (!token_ok() || (flg.aux && acc_r != 64'd0)) begin
                    go_skip(ST_BAD_INT);
                end else begin
                    add_header(acc_r[31:0]);
                    if (acc_r == 64'd0) begin
                        go_skip(ST_OK);
                    end else begin
                        cols_r = acc_r[31:0];
                        ph     = PH_ATTR;
                        start_token(1'b0);
                    end
                end
            end
            PH_ATTR: begin
                if (b != CH_TAB) begin
                    feed_digit(b, 1'b1, INT_LIMIT);
                end else if (!token_ok()) begin
                    go_skip(ST_BAD_INT);
                end else begin
                    // non-positive attribute fails once its column is done
                    if (flg.aux || acc_r == 64'd0) begin
                        err_r  = ST_BAD_ATTR;
                        attr_r = '0;
                    end else begin
                        err_r  = ST_OK;
                        attr_r = acc_r[31:0];
                    end
                    ph = PH_NULL;
                    start_token(1'b0);
                end
            end
            PH_NULL: begin
                if (b == CH_TAB) begin
                    if (!flg.digit || flg.bad) begin
                        go_skip(ST_BAD_NULL);
                    end else begin
                        ph = PH_LEN;
                        start_token(1'b1);
                    end
                end else if (flg.digit || (b != CH_N && b != CH_V)) begin
                    flg.bad = 1'b1;
                end else begin
                    flg.digit = 1'b1;
                    if (b == CH_N)
                        flg.aux = 1'b1;
                end
            end
            PH_LEN: begin
                if (b != CH_COLON) begin
                    feed_digit(b, 1'b0, LEN_LIMIT);
                end else if (!token_ok()) begin
                    go_skip(ST_BAD_INT);
                end else begin
                    remain_r = acc_r;
                    if (err_r != ST_BAD_ATTR)
                        add_column();
                    if (remain_r == 64'd0)
                        finish_value();
                    else
                        ph = PH_VALUE;
                end
            end
            PH_VALUE: begin
                // null columns and bad attributes swallow their bytes
                if (!flg.aux && err_r != ST_BAD_ATTR)
                    add_value(b);
                remain_r = remain_r - 64'd1;
                if (remain_r == 64'd0)
                    finish_value();
            end
            PH_SEP: begin
                if (b != CH_TAB) begin
                    go_skip(ST_BAD_SEP);
                end else if (err_r == ST_BAD_ATTR) begin
                    go_skip(ST_BAD_ATTR);
                end else begin
                    cols_r = cols_r - 32'd1;
                    ph     = PH_ATTR;
                    start_token(1'b0);
                end
            end
            default: ;
        endcase

        // Record end: status from where the parse stopped
        if (eor) begin
            case (ph)
                PH_RELID: begin
                    if (!flg.digit && !flg.bad) begin
                        st = ST_MALFORMED;
                    end else if (!token_ok()) begin
                        st = ST_BAD_INT;
                    end else if (act_r != CH_I) begin
                        rel_r = acc_r[31:0];
                        add_header('0);
                        st = ST_OK;
                    end else begin
                        st = ST_MALFORMED;
                    end
                end
                PH_LEN:   st = ST_NO_COLON;
                PH_VALUE: st = ST_TRUNCATED;
                PH_SEP:   st = ST_BAD_SEP;
                PH_SKIP:  st = err_r;
                default:  st = ST_MALFORMED;
            endcase
            add_end(st);
            clear_parser();
        end

        for (int i = 0; i < step_rows.size(); i++) begin
            r = step_rows[i];
            r.last = (i == step_rows.size() - 1);
            pending_events.insert(pending_events.size(), r);
        end
    endfunction

    function automatic string row_text(row_t r);
        return $sformatf({"kind=%0d act=%02h rel=%08h cnt=%0d attr=%0d null=%0b ",
                          "len=%08h byte=%02h st=%0d last=%0b"},
                         r.kind, r.action, r.relation, r.count, r.attr, r.is_null,
                         r.length, r.vbyte, r.status, r.last);
    endfunction

    // ---------------------------------------------------------------
    // Result side: random ready and event checking
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_row.kind     = event_kind_t'(m_event_kind);
            got_row.action   = m_action_code;
            got_row.relation = m_relation_id;
            got_row.count    = m_column_count;
            got_row.attr     = m_attribute_number;
            got_row.is_null  = m_value_is_null;
            got_row.length   = m_value_length;
            got_row.vbyte    = m_value_byte;
            got_row.status   = status_t'(m_record_status);
            got_row.last     = m_last_of_step;
            if (pending_events.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected event: %s", row_text(got_row));
            end else begin
                want_row = pending_events.pop_front();
                if (got_row !== want_row) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("event mismatch at cycle %0d", cycle_cnt);
                        $display("  expected %s", row_text(want_row));
                        $display("  actual   %s", row_text(got_row));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d events outstanding", pending_events.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Byte side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eor);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_record <= eor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_parser_events(b, eor);
        bytes_sent++;
    endtask

    // Send the assembled record, end marker on its last byte
    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++)
            send_byte(rec_q[i], i == rec_q.size() - 1);
        rec_q.delete();
    endtask

    // Hold off the sender until every expected event has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Append one byte to the record under construction
    function automatic void put_byte(logic [7:0] b);
        rec_q.insert(rec_q.size(), b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    function automatic void put_num(longint v);
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_junk(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            put_byte(8'($urandom_range(0, 255)));
    endfunction

    // Insert record with random content; a zero or negative attribute makes it fail
    function automatic void build_insert_record();
        int     ncols;
        int     len;
        longint attr;
        put_byte(CH_I);
        put_byte(CH_TAB);
        case ($urandom_range(0, 9))
            0:       put_num(0);
            1:       put_num(longint'(REL_LIMIT));
            default: put_num(longint'($urandom));
        endcase
        put_byte(CH_TAB);
        case ($urandom_range(0, 19))
            0:       ncols = 0;
            1:       ncols = -1;
            default: ncols = $urandom_range(1, 4);
        endcase
        // zero columns, plain or with a minus sign
        if (ncols <= 0) begin
            put_str(ncols < 0 ? "-0" : "0");
            put_byte(CH_TAB);
            put_junk(0, 3);
            return;
        end
        put_num(ncols);
        put_byte(CH_TAB);
        for (int c = 0; c < ncols; c++) begin
            case ($urandom_range(0, 19))
                0:       attr = 0;
                1:       attr = -longint'($urandom_range(1, 2147483647));
                2:       attr = 2147483647;
                3:       attr = $urandom_range(1, 2147483647);
                default: attr = $urandom_range(1, 300);
            endcase
            put_num(attr);
            put_byte(CH_TAB);
            put_byte($urandom_range(0, 4) == 0 ? CH_N : CH_V);
            put_byte(CH_TAB);
            len = $urandom_range(0, 6);
            put_num(len);
            put_byte(CH_COLON);
            put_junk(len, len);
            if (c < ncols - 1)
                put_byte(CH_TAB);
        end
        if ($urandom_range(0, 4) == 0)
            put_junk(1, 3);
    endfunction

    // Non-insert record, optionally with ignored bytes after the relation id
    function automatic void build_other_record();
        logic [7:0] a;
        do a = 8'($urandom_range(0, 255)); while (a == CH_I);
        put_byte(a);
        put_byte(CH_TAB);
        put_num(longint'($urandom));
        case ($urandom_range(0, 2))
            0: ;
            1: put_byte(CH_TAB);
            default: begin
                put_byte(CH_TAB);
                put_junk(1, 4);
            end
        endcase
    endfunction

    // Cut short or corrupt one byte of an otherwise good record
    function automatic void build_broken_record();
        int n;
        if ($urandom_range(0, 9) < 7)
            build_insert_record();
        else
            build_other_record();
        if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(1, rec_q.size());
            while (rec_q.size() > n)
                void'(rec_q.pop_back());
        end else begin
            n = $urandom_range(0, rec_q.size() - 1);
            case ($urandom_range(0, 4))
                0:       rec_q[n] = CH_TAB;
                1:       rec_q[n] = CH_COLON;
                2:       rec_q[n] = CH_MINUS;
                3:       rec_q[n] = CH_9;
                default: rec_q[n] = 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    function automatic void set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic directed(string s);
        put_str(s);
        send_record();
    endtask

    // Field extremes and each way a record can end or fail
    task automatic test_directed_cases();
        // widest relation id, count and attribute, extreme value bytes, cut at separator
        put_str("I\t4294967295\t2147483647\t2147483647\tv\t2:");
        put_byte(8'h00);
        put_byte(8'hFF);
        send_record();
        directed("U\t0");                         // end terminates the relation id
        directed("D\t4294967296");                // relation id overflow
        directed("D\t");                          // empty relation id
        directed("D\t12\tx-9");                   // trailing bytes ignored
        directed("Q");                            // lone action byte
        directed("Ax1");                          // missing tab after action
        directed("I\t7");                         // insert ends inside relation id
        directed("I\t9\t");                       // insert ends after relation id
        directed("I\t7\t-0\tzz");                 // minus zero columns
        directed("I\t7\t-2147483648\t");          // negative count
        directed("I\t7\t2147483648\t");           // count overflow
        directed("I\t7\t3");                      // end inside count
        directed("I\t1\t2\t-2147483648\tv\t3:abc\t5\tv\t1:z"); // negative attribute
        directed("I\t1\t1\t0\tn\t1:q");           // zero attribute on last column
        directed("I\t1\t1\t12");                  // end inside attribute
        directed("I\t1\t1\t--5\t");               // double minus
        directed("I\t1\t1\t5\tvn\t");             // two null markers
        directed("I\t1\t1\t5\t\t");               // empty null marker
        directed("I\t1\t1\t5\tn");                // end inside null marker
        directed("I\t1\t1\t5\tn\t4:abcd");        // null value, bytes swallowed
        directed("I\t1\t1\t5\tv\t4294967295:ab"); // widest length, truncated
        directed("I\t1\t1\t5\tv\t4294967296:");   // length overflow
        directed("I\t1\t1\t5\tv\t12");            // missing colon
        directed("I\t1\t2\t5\tv\t0:\t6\tn\t2:xy");// empty value, then null column
        directed("I\t1\t2\t5\tv\t0:x");           // bad separator between columns
    endtask

    // Mostly well-formed records, the rest broken records and noise
    task automatic test_random_records(int n_bytes);
        int stop;
        int pick;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                build_insert_record();
            else if (pick < 75)
                build_other_record();
            else if (pick < 95)
                build_broken_record();
            else
                put_junk(1, 10);
            send_record();
        end
    endtask

    initial begin
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_idle(6, 61);
        test_directed_cases();
        test_random_records(420);
        drain_results();

        set_idle(61, 6);
        test_random_records(420);
        drain_results();

        set_idle(0, 0);
        test_random_records(420);
        drain_results();

        repeat (8) @(posedge aclk);
        err_count += pending_events.size();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
